// ===== hdl/wbbs_pkg.sv =====
// Package for the world box background shader: widths, register indexes,
// face colours and the queue entry types. No dependencies.
package wbbs_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 63;
    localparam int CompW = 21;
    localparam int DirW = 40;
    localparam int NumW = 39;
    localparam int QuoW = 39;
    localparam int ColW = 24;
    localparam int DefMaxWidth = 2048;
    localparam int DefMaxHeight = 2048;

    localparam logic [CfgIdxW-1:0] REG_RIGHT = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_UP = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FORWARD = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_NEAR = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FAR = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_WIDTH = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_LIMIT = 3'd7;

    function automatic logic [ColW-1:0] face_colour(input logic [2:0] f);
        logic [ColW-1:0] c;
        case (f)
            3'd0: c = 24'h6F6F00;
            3'd1: c = 24'h6F006F;
            3'd2: c = 24'h006F00;
            3'd3: c = 24'h00006F;
            3'd4: c = 24'h888888;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic        painted;
        logic        start;
        logic [12:0] tx;
        logic [12:0] ty;
    } pix_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIR,
        ST_NEAR,
        ST_FAR,
        ST_NEXT,
        ST_DONE
    } eng_state_t;

endpackage

// ===== hdl/world_box_background_shader.sv =====
// Top level of the world box background shader: configuration registers,
// front queue and back-end engine. Depends on wbbs_pkg, wbbs_front, wbbs_engine.
//
// Usage: push pixels (pix_x, pix_y, already_painted, frame_start) in raster
// order while full is low; a transfer happens when push is high and full low.
// Results (colour, write_enable) wait on the ports while empty is low and
// transfer when pop is high. A two-entry queue parts the front from the engine,
// and a one-entry output register parts the engine from the receiver, so the
// front keeps taking pixels while a result waits.
// Steps: a painted pixel is taken, classified and written out. An unpainted
// pixel goes, for each axis, through the direction steps, up to two divisions
// in the shared restoring divider (one quotient bit per cycle) and one step
// state, and is then written out.
// One pixel is worked on at a time.
// Reset clears the queue, the output register, the carried colour and the
// registers to their defaults. When the receiver stalls the engine holds its
// finished result and then the queue fills and full rises.
// Write configuration only while idle.
module world_box_background_shader
    import wbbs_pkg::*;
#(
    parameter int MaxWidth = DefMaxWidth,
    parameter int MaxHeight = DefMaxHeight
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [10:0]         pix_x,
    input  logic [10:0]         pix_y,
    input  logic                already_painted,
    input  logic                frame_start,
    output logic                empty,
    input  logic                pop,
    output logic [ColW-1:0]     colour,
    output logic                write_enable
);
    logic [CfgDataW-1:0] right_reg, up_reg, fwd_reg, near_reg, far_reg;
    logic [11:0] width_reg, height_reg;
    logic [15:0] limit_reg;
    logic [12:0] w_next, h_next;
    logic item_valid, item_take;
    pix_item_t item;

    // saturate viewport sizes to the supported maximum
    assign w_next = ({1'b0, cfg_data[11:0]} > 13'(MaxWidth)) ? 13'(MaxWidth)
                    : {1'b0, cfg_data[11:0]};
    assign h_next = ({1'b0, cfg_data[11:0]} > 13'(MaxHeight)) ? 13'(MaxHeight)
                    : {1'b0, cfg_data[11:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg <= '0;
            up_reg <= '0;
            fwd_reg <= '0;
            near_reg <= '0;
            far_reg <= '0;
            width_reg <= 12'd640;
            height_reg <= 12'd480;
            limit_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RIGHT: right_reg <= cfg_data;
                REG_UP: up_reg <= cfg_data;
                REG_FORWARD: fwd_reg <= cfg_data;
                REG_NEAR: near_reg <= cfg_data;
                REG_FAR: far_reg <= cfg_data;
                REG_WIDTH: width_reg <= w_next[11:0];
                REG_HEIGHT: height_reg <= h_next[11:0];
                REG_LIMIT: limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    wbbs_front #(.Depth(2)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .pix_x(pix_x), .pix_y(pix_y), .already_painted(already_painted),
        .frame_start(frame_start),
        .half_w({1'b0, width_reg[11:1]}), .half_h({1'b0, height_reg[11:1]}),
        .item_valid(item_valid), .item(item), .item_take(item_take)
    );

    wbbs_engine u_engine (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item(item),
        .item_take(item_take), .right_reg(right_reg), .up_reg(up_reg),
        .fwd_reg(fwd_reg), .near_reg(near_reg), .far_reg(far_reg),
        .limit_reg(limit_reg), .empty(empty), .pop(pop), .colour(colour),
        .write_enable(write_enable)
    );
endmodule

// ===== hdl/wbbs_front.sv =====
// Front end: takes pixels, forms signed view offsets, buffers them in a
// short queue. Depends on wbbs_pkg.
module wbbs_front
    import wbbs_pkg::*;
#(
    parameter int Depth = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [10:0]  pix_x,
    input  logic [10:0]  pix_y,
    input  logic         already_painted,
    input  logic         frame_start,
    input  logic [11:0]  half_w,
    input  logic [11:0]  half_h,
    output logic         item_valid,
    output pix_item_t    item,
    input  logic         item_take
);
    localparam int PtrW = $clog2(Depth);
    pix_item_t mem_reg [Depth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0] cnt_reg;
    pix_item_t in_item;
    logic do_push, do_pop;

    always_comb
    begin
        in_item.painted = already_painted;
        in_item.start = frame_start;
        in_item.tx = 13'($signed({1'b0, half_w}) - 13'sd1 - $signed({2'b0, pix_x}));
        in_item.ty = 13'($signed({1'b0, half_h}) - 13'sd1 - $signed({2'b0, pix_y}));
    end

    assign full = (cnt_reg == (PtrW+1)'(Depth));
    assign item_valid = (cnt_reg != '0);
    assign item = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop = item_take && item_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PtrW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PtrW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
        end
    end
endmodule

// ===== hdl/wbbs_divider.sv =====
// Restoring divider, one quotient bit per cycle. Computes num/den unsigned.
// Depends on wbbs_pkg.
module wbbs_divider
    import wbbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [DirW-1:0] den,
    output logic            done,
    output logic [QuoW-1:0] quo
);
    localparam int CntW = $clog2(NumW+1);
    logic [QuoW-1:0] q_reg;
    logic [DirW:0] rem_reg;
    logic [DirW-1:0] den_reg;
    logic [CntW-1:0] cnt_reg;
    logic busy_reg;
    logic [DirW:0] shifted, diff;

    assign shifted = {rem_reg[DirW-1:0], q_reg[QuoW-1]};
    assign diff = shifted - {1'b0, den_reg};
    assign quo = q_reg;
    assign done = busy_reg && (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!diff[DirW])
            begin
                rem_reg <= diff;
                q_reg <= {q_reg[QuoW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[QuoW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CntW'(NumW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/wbbs_engine.sv =====
// Back end: per-axis ray direction, face quotients through the shared
// divider, nearest-hit selection, carried colour and output register.
// Depends on wbbs_pkg and wbbs_divider.
module wbbs_engine
    import wbbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  pix_item_t           item,
    output logic                item_take,
    input  logic [CfgDataW-1:0] right_reg,
    input  logic [CfgDataW-1:0] up_reg,
    input  logic [CfgDataW-1:0] fwd_reg,
    input  logic [CfgDataW-1:0] near_reg,
    input  logic [CfgDataW-1:0] far_reg,
    input  logic [15:0]         limit_reg,
    output logic                empty,
    input  logic                pop,
    output logic [ColW-1:0]     colour,
    output logic                write_enable
);
    eng_state_t state_reg, state_next;
    pix_item_t cur_reg;
    logic [1:0] axis_reg;
    logic [1:0] mstep_reg;
    logic signed [DirW-1:0] dir_reg;
    logic signed [DirW-1:0] prod_reg;
    logic [QuoW-1:0] bound_reg;
    logic [ColW-1:0] carry_reg;
    logic [ColW-1:0] out_col_reg;
    logic out_we_reg, out_full_reg;
    logic div_pend_reg;

    logic signed [CompW-1:0] cr, cu, cf, cn, cfa, off;
    logic signed [CompW+13:0] mul;
    logic signed [DirW-1:0] dir_sum;
    logic div_start, div_done, off_ok;
    logic [QuoW-1:0] quo;
    logic [NumW-1:0] num;
    logic [DirW-1:0] den;
    logic hit, accept_item, out_free;

    always_comb
    begin
        cr = right_reg[21*axis_reg +: CompW];
        cu = up_reg[21*axis_reg +: CompW];
        cf = fwd_reg[21*axis_reg +: CompW];
        cn = near_reg[21*axis_reg +: CompW];
        cfa = far_reg[21*axis_reg +: CompW];
        mul = (mstep_reg == 2'd0) ? cr * $signed(cur_reg.tx) : cu * $signed(cur_reg.ty);
        dir_sum = prod_reg + DirW'($signed({cf, 12'd0}));
        off = (state_reg == ST_FAR) ? cfa : cn;
        off_ok = (off != 0) && (off[CompW-1] == dir_reg[DirW-1]);
        num = {(off[CompW-1] ? CompW'(-off) : CompW'(off)), 18'd0};
        den = dir_reg[DirW-1] ? DirW'(-dir_reg) : DirW'(dir_reg);
        hit = div_done && (quo >= QuoW'(64)) && (quo < bound_reg);
    end

    wbbs_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(den),
        .done(div_done), .quo(quo)
    );

    assign out_free = !out_full_reg || pop;
    assign empty = !out_full_reg;
    assign colour = out_col_reg;
    assign write_enable = out_we_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (item_valid)
                begin
                    state_next = ST_DIR;
                end
            ST_DIR:
                if (cur_reg.painted)
                begin
                    state_next = ST_DONE;
                end
                else if (mstep_reg == 2'd2)
                begin
                    state_next = (dir_sum == '0) ? ST_NEXT : ST_NEAR;
                end
            ST_NEAR:
                if (!div_pend_reg && !off_ok)
                begin
                    state_next = ST_FAR;
                end
                else if (div_done)
                begin
                    state_next = (quo >= QuoW'(64)) ? ST_NEXT : ST_FAR;
                end
            ST_FAR:
                if ((!div_pend_reg && !off_ok) || div_done)
                begin
                    state_next = ST_NEXT;
                end
            ST_NEXT:
                state_next = (axis_reg == 2'd2) ? ST_DONE : ST_DIR;
            ST_DONE:
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        accept_item = (state_reg == ST_IDLE) && item_valid;
        item_take = accept_item;
        div_start = ((state_reg == ST_NEAR) || (state_reg == ST_FAR))
                    && !div_pend_reg && off_ok;
    end

    always_ff @(posedge clk)
    begin
        if (accept_item)
        begin
            cur_reg <= item;
        end
        if (state_reg == ST_DIR)
        begin
            if (mstep_reg == 2'd2)
            begin
                dir_reg <= dir_sum;
            end
            else
            begin
                prod_reg <= (mstep_reg == 2'd0) ? DirW'(mul) : prod_reg + DirW'(mul);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg <= '0;
            mstep_reg <= '0;
            bound_reg <= '0;
            carry_reg <= '0;
            out_full_reg <= 1'b0;
            out_col_reg <= '0;
            out_we_reg <= 1'b0;
            div_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
            if (accept_item)
            begin
                axis_reg <= '0;
                mstep_reg <= '0;
                bound_reg <= QuoW'({limit_reg, 6'd0});
                if (item.start)
                begin
                    carry_reg <= '0;
                end
            end
            if (state_reg == ST_DIR)
            begin
                mstep_reg <= (mstep_reg == 2'd2) ? 2'd0 : mstep_reg + 2'd1;
            end
            if (div_start)
            begin
                div_pend_reg <= 1'b1;
            end
            else if (div_done)
            begin
                div_pend_reg <= 1'b0;
            end
            if (hit)
            begin
                bound_reg <= quo;
                carry_reg <= face_colour({axis_reg, state_reg == ST_FAR});
            end
            if (state_reg == ST_NEXT)
            begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_full_reg <= 1'b1;
                out_we_reg <= !cur_reg.painted;
                out_col_reg <= cur_reg.painted ? '0 : carry_reg;
            end
        end
    end
endmodule

// ===== hdl/wbbs_checker.sv =====
// Port-level checker for the world box background shader, bound to the top.
// Depends on wbbs_pkg.
module wbbs_checker
    import wbbs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            full,
    input  logic            empty,
    input  logic            pop,
    input  logic [ColW-1:0] colour,
    input  logic            write_enable
);
    // a waiting result holds until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(colour) && $stable(write_enable)))
        else $error("result changed while waiting");

    // a painted pixel reports black
    a_painted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_enable) |-> (colour == '0))
        else $error("painted pixel with colour");

    // nothing waits right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present after reset");

    // handshake outputs are always driven
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("full or empty unknown");
endmodule

bind world_box_background_shader wbbs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .colour(colour), .write_enable(write_enable)
);
